FILE: hdl/dwo_pkg.sv
// Shared constants and opcode codes for the dual wavetable oscillator.
package dwo_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 1024;
    localparam int DEFAULT_FRACTION_BITS = 16;

    localparam int SAMPLE_BITS      = 16;
    localparam int RATE_BITS        = 24;
    localparam int SCALE_BITS       = 16;
    localparam int SCALE_FRAC       = 12;
    localparam int INDEX_FIELD_BITS = 10;
    localparam int OPCODE_BITS      = 2;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(4096);

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_GENERATE     = 2'd0,
        OP_WRITE_FIRST  = 2'd1,
        OP_WRITE_SECOND = 2'd2
    } opcode_t;

endpackage

FILE: hdl/dual_wavetable_oscillator.sv
// Dual wavetable oscillator: two interpolated tables sharing one phase accumulator.
//
// Input channel (in_valid / in_stall): one item per transfer. Opcodes one and two
// store entry_value into table one or two at entry_index; opcode zero reads both
// tables at the current phase and returns one result. Opcode three is dropped.
// Output channel (out_valid / out_stall): first_sample and second_sample of one
// generate step per transfer, in input order. Configuration channel
// (cfg_valid / cfg_ready, always ready): writes phase_scale, which must be written
// only while idle; the block does not enforce this. Throughput: one item per cycle
// unless the output stalls; the phase accumulate (rate times phase_scale, then add)
// is combinational, and each table port does one read per cycle.
// TABLE_ENTRIES must be a power of two. Tables must be loaded before stepping.
// Reset: phase clears to zero, phase_scale to 1.0, both pipeline stages empty;
// table contents are not cleared. When the receiver stalls, the result register
// holds, the read stage holds behind it, and in_stall rises once both are full.
module dual_wavetable_oscillator #(
    parameter int TABLE_ENTRIES = dwo_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int FRACTION_BITS = dwo_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [dwo_pkg::SCALE_BITS-1:0]           cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [dwo_pkg::OPCODE_BITS-1:0]          opcode,
    input  logic signed [dwo_pkg::RATE_BITS-1:0]     rate,
    input  logic [dwo_pkg::INDEX_FIELD_BITS-1:0]     entry_index,
    input  logic signed [dwo_pkg::SAMPLE_BITS-1:0]   entry_value,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [dwo_pkg::SAMPLE_BITS-1:0]   first_sample,
    output logic signed [dwo_pkg::SAMPLE_BITS-1:0]   second_sample
);

    import dwo_pkg::*;

    localparam int INDEX_BITS       = $clog2(TABLE_ENTRIES);
    localparam int PHASE_BITS       = INDEX_BITS + FRACTION_BITS;
    localparam int SCALE_PROD_BITS  = RATE_BITS + SCALE_BITS + 1;
    localparam int INC_BITS         = SCALE_PROD_BITS - SCALE_FRAC;
    localparam int SUM_BITS         = PHASE_BITS + INC_BITS;
    localparam int WIDE_INDEX_BITS  = INDEX_BITS + INDEX_FIELD_BITS;
    localparam int DIFF_BITS        = SAMPLE_BITS + 1;
    localparam int INTERP_PROD_BITS = DIFF_BITS + FRACTION_BITS + 1;
    localparam int STEP_BITS        = INTERP_PROD_BITS - FRACTION_BITS;

    logic [PHASE_BITS-1:0]              phase_reg;
    logic [PHASE_BITS-1:0]              phase_next;
    logic [SCALE_BITS-1:0]              phase_scale_reg;
    logic signed [SCALE_PROD_BITS-1:0]  scale_prod;
    logic [INC_BITS-1:0]                phase_inc;
    logic [SUM_BITS-1:0]                phase_sum;

    logic                               accept;
    logic                               gen_step;
    logic                               write_first;
    logic                               write_second;
    logic [WIDE_INDEX_BITS-1:0]         wide_index;
    logic                               index_ok;
    logic [INDEX_BITS-1:0]              write_addr;
    logic [INDEX_BITS-1:0]              read_idx;
    logic [INDEX_BITS-1:0]              read_nxt;

    logic                               s1_advance;
    logic                               out_advance;
    logic                               s1_valid_reg;
    logic [FRACTION_BITS-1:0]           frac_reg;
    logic                               out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]      first_sample_reg;
    logic signed [SAMPLE_BITS-1:0]      second_sample_reg;

    logic [SAMPLE_BITS-1:0]             first_a;
    logic [SAMPLE_BITS-1:0]             first_b;
    logic [SAMPLE_BITS-1:0]             second_a;
    logic [SAMPLE_BITS-1:0]             second_b;

    function automatic logic signed [SAMPLE_BITS-1:0] lerp(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b,
        input logic [FRACTION_BITS-1:0]      f
    );
        logic signed [DIFF_BITS-1:0]        diff;
        logic signed [INTERP_PROD_BITS-1:0] prod;
        logic signed [STEP_BITS-1:0]        step;
        logic [STEP_BITS-1:0]               total;
        diff  = {b[SAMPLE_BITS-1], b} - {a[SAMPLE_BITS-1], a};
        prod  = diff * $signed({1'b0, f});
        step  = prod[INTERP_PROD_BITS-1:FRACTION_BITS];
        total = step + {{(STEP_BITS-SAMPLE_BITS){a[SAMPLE_BITS-1]}}, a};
        return total[SAMPLE_BITS-1:0];
    endfunction

    assign cfg_ready   = 1'b1;
    assign out_advance = !out_valid_reg || !out_stall;
    assign s1_advance  = !s1_valid_reg || out_advance;
    assign in_stall    = !s1_advance;
    assign accept      = in_valid && s1_advance;

    assign gen_step     = (opcode == OP_GENERATE);
    assign write_first  = (opcode == OP_WRITE_FIRST);
    assign write_second = (opcode == OP_WRITE_SECOND);

    assign wide_index = {{INDEX_BITS{1'b0}}, entry_index};
    assign index_ok   = (wide_index < WIDE_INDEX_BITS'(TABLE_ENTRIES));
    assign write_addr = wide_index[INDEX_BITS-1:0];

    assign read_idx = phase_reg[PHASE_BITS-1:FRACTION_BITS];
    assign read_nxt = read_idx + INDEX_BITS'(1);

    assign scale_prod = rate * $signed({1'b0, phase_scale_reg});
    assign phase_inc  = scale_prod[SCALE_PROD_BITS-1:SCALE_FRAC];
    assign phase_sum  = {{INC_BITS{1'b0}}, phase_reg}
                      + {{PHASE_BITS{phase_inc[INC_BITS-1]}}, phase_inc};
    assign phase_next = phase_sum[PHASE_BITS-1:0];

    dwo_table #(
        .ENTRIES (TABLE_ENTRIES),
        .WIDTH   (SAMPLE_BITS)
    ) u_first_table (
        .clk       (clk),
        .wr_en     (accept && write_first && index_ok),
        .wr_addr   (write_addr),
        .wr_data   (entry_value),
        .rd_en     (s1_advance),
        .rd_addr_a (read_idx),
        .rd_addr_b (read_nxt),
        .rd_data_a (first_a),
        .rd_data_b (first_b)
    );

    dwo_table #(
        .ENTRIES (TABLE_ENTRIES),
        .WIDTH   (SAMPLE_BITS)
    ) u_second_table (
        .clk       (clk),
        .wr_en     (accept && write_second && index_ok),
        .wr_addr   (write_addr),
        .wr_data   (entry_value),
        .rd_en     (s1_advance),
        .rd_addr_a (read_idx),
        .rd_addr_b (read_nxt),
        .rd_data_a (second_a),
        .rd_data_b (second_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= '0;
            phase_scale_reg <= SCALE_RESET;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                phase_scale_reg <= cfg_data;
            end
            if (accept && gen_step)
            begin
                phase_reg <= phase_next;
            end
            if (s1_advance)
            begin
                s1_valid_reg <= accept && gen_step;
            end
            if (out_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            frac_reg <= phase_reg[FRACTION_BITS-1:0];
        end
        if (out_advance)
        begin
            first_sample_reg  <= lerp(first_a, first_b, frac_reg);
            second_sample_reg <= lerp(second_a, second_b, frac_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign first_sample  = first_sample_reg;
    assign second_sample = second_sample_reg;

endmodule

FILE: hdl/dwo_table.sv
// Sample table: one write port, two read ports with registered read data.
module dwo_table #(
    parameter int ENTRIES = dwo_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int WIDTH   = dwo_pkg::SAMPLE_BITS
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr_a,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]           rd_data_a,
    output logic [WIDTH-1:0]           rd_data_b
);

    logic [WIDTH-1:0] mem_reg [ENTRIES];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= mem_reg[rd_addr_a];
            rd_data_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule
